// ===== design/rtfd_pkg.sv =====
package rtfd_pkg;

    localparam int unsigned FRAME_LEN  = 8;
    localparam int unsigned FILL_W     = 4;
    localparam int unsigned DEC_W      = 27;
    localparam int unsigned DEC_HI_W   = 14;   // holds up to four decimal digits

    localparam logic [7:0] HEADER_BYTE = 8'hDD;
    localparam logic [7:0] TAIL_BYTE   = 8'h55;
    localparam logic [3:0] DIGIT_MAX   = 4'd9;

    // frame queue between front and back
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = 1;
    localparam int unsigned QCNT_W = 2;

    typedef struct packed {
        logic [31:0] tag_id;
        logic [7:0]  status;
        logic        chk_err;
    } frame_t;

endpackage

// ===== design/rtfd_front.sv =====
module rtfd_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_rx_byte,
    input  logic            s_chunk_end,
    input  logic            q_full,
    output logic            q_push,
    output rtfd_pkg::frame_t q_wdata
);
    import rtfd_pkg::*;

    logic [63:0]       window_reg, window_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [63:0]       shifted;
    logic [FILL_W-1:0] fill_inc;
    logic              accept;
    logic              match;
    logic [7:0]        xsum;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        shifted  = {window_reg[55:0], s_rx_byte};
        fill_inc = (fill_reg >= FILL_W'(FRAME_LEN)) ? FILL_W'(FRAME_LEN)
                                                    : fill_reg + FILL_W'(1);
        match    = (fill_inc == FILL_W'(FRAME_LEN)) &&
                   (shifted[63:56] == HEADER_BYTE) && (shifted[7:0] == TAIL_BYTE);
        xsum     = shifted[63:56] ^ shifted[55:48] ^ shifted[47:40] ^
                   shifted[39:32] ^ shifted[31:24] ^ shifted[23:16];

        q_wdata.tag_id  = shifted[55:24];
        q_wdata.status  = shifted[23:16];
        q_wdata.chk_err = (xsum != shifted[15:8]);
        q_push          = accept && match;

        window_next = window_reg;
        fill_next   = fill_reg;
        if (accept) begin
            if (match || s_chunk_end) begin
                window_next = '0;
                fill_next   = '0;
            end else begin
                window_next = shifted;
                fill_next   = fill_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            fill_reg   <= '0;
        end else begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== design/rtfd_queue.sv =====
module rtfd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  rtfd_pkg::frame_t wdata,
    output logic             full,
    input  logic             pop,
    output logic             rvalid,
    output rtfd_pkg::frame_t rdata
);
    import rtfd_pkg::*;

    frame_t            mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign rvalid  = (cnt_reg != '0);
    assign rdata   = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && rvalid;

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

endmodule

// ===== design/rtfd_back.sv =====
module rtfd_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  rtfd_pkg::frame_t q_rdata,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [31:0]      m_tag_id_raw,
    output logic [26:0]      m_tag_id_decimal,
    output logic             m_checksum_error,
    output logic             m_alarm_flag,
    output logic [2:0]       m_filter_level,
    output logic [2:0]       m_field_strength,
    output logic             m_low_battery
);
    import rtfd_pkg::*;

    // stage 1: upper four nibbles
    logic                s1_valid_reg;
    frame_t              s1_frame_reg;
    logic [DEC_HI_W-1:0] s1_acc_reg, s1_acc_next;
    logic                s1_stop_reg, s1_stop_next;

    // output stage
    logic                m_valid_reg;
    frame_t              m_frame_reg;
    logic [DEC_W-1:0]    m_dec_reg, m_dec_next;

    logic                out_en, s1_en;

    assign out_en = !m_valid_reg || m_ready;
    assign s1_en  = !s1_valid_reg || out_en;
    assign q_pop  = s1_en;

    always_comb begin
        logic [3:0] nib;
        nib          = '0;
        s1_acc_next  = '0;
        s1_stop_next = 1'b0;
        for (int k = 0; k < 4; k++) begin
            nib = q_rdata.tag_id[31 - 4*k -: 4];
            if (!s1_stop_next && (nib <= DIGIT_MAX)) begin
                s1_acc_next = DEC_HI_W'((s1_acc_next << 3) + (s1_acc_next << 1)
                                        + {{(DEC_HI_W-4){1'b0}}, nib});
            end else begin
                s1_stop_next = 1'b1;
            end
        end
    end

    always_comb begin
        logic [3:0] nib;
        logic       stop;
        nib        = '0;
        stop       = s1_stop_reg;
        m_dec_next = {{(DEC_W-DEC_HI_W){1'b0}}, s1_acc_reg};
        for (int k = 0; k < 4; k++) begin
            nib = s1_frame_reg.tag_id[15 - 4*k -: 4];
            if (!stop && (nib <= DIGIT_MAX)) begin
                m_dec_next = DEC_W'((m_dec_next << 3) + (m_dec_next << 1)
                                    + {{(DEC_W-4){1'b0}}, nib});
            end else begin
                stop = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_en && q_valid) begin
            s1_frame_reg <= q_rdata;
            s1_acc_reg   <= s1_acc_next;
            s1_stop_reg  <= s1_stop_next;
        end
        if (out_en && s1_valid_reg) begin
            m_frame_reg <= s1_frame_reg;
            m_dec_reg   <= m_dec_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_en) begin
                s1_valid_reg <= q_valid;
            end
            if (out_en) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_tag_id_raw     = m_frame_reg.tag_id;
    assign m_tag_id_decimal = m_dec_reg;
    assign m_checksum_error = m_frame_reg.chk_err;
    assign m_alarm_flag     = m_frame_reg.status[7];
    assign m_filter_level   = m_frame_reg.status[6:4];
    assign m_field_strength = m_frame_reg.status[3:1];
    assign m_low_battery    = !m_frame_reg.status[0];

endmodule

// ===== design/rfid_tag_frame_deframer_unit.sv =====
// RFID tag frame deframer. Takes one received serial byte per transaction on
// the s_ channel and slides it into an 8-byte window. When the window is full,
// its oldest byte is the 0xDD header and its newest the 0x55 tail, one result
// transaction goes out on the m_ channel and the window empties; s_chunk_end
// also empties the window once its byte has been handled. Frame layout, oldest
// first: header, tag ID (4 bytes, MSB first), status, check byte, tail. The
// result carries the raw ID, the ID's nibbles read as decimal digits (stopping
// before the first nibble above 9), a checksum error flag (XOR of the first six
// bytes against the check byte; the result is still sent on a mismatch) and
// the decoded status bits. Rate: one byte per cycle, sustained while s_ready
// is high. A result reaches m_valid through these registers in turn: the
// accepting edge writes the frame into the two-entry frame queue, then two
// register stages carry the decimal conversion, four nibbles per stage.
// s_ready drops only while the frame queue is full, which takes a stalled
// m_ready over several frames.
module rfid_tag_frame_deframer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // byte stream in
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_chunk_end,
    // decoded frames out
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_tag_id_raw,
    output logic [26:0] m_tag_id_decimal,
    output logic        m_checksum_error,
    output logic        m_alarm_flag,
    output logic [2:0]  m_filter_level,
    output logic [2:0]  m_field_strength,
    output logic        m_low_battery
);
    import rtfd_pkg::*;

    // front -> queue
    logic   q_push;
    logic   q_full;
    frame_t q_wdata;
    // queue -> back
    logic   q_valid;
    logic   q_pop;
    frame_t q_rdata;

    // Front: window, frame match and checksum
    rtfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .s_chunk_end (s_chunk_end),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    // Decouples byte intake from result back-pressure
    rtfd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rvalid  (q_valid),
        .rdata   (q_rdata)
    );

    // Back: hex-nibble to decimal conversion and output register
    rtfd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_rdata          (q_rdata),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_tag_id_raw     (m_tag_id_raw),
        .m_tag_id_decimal (m_tag_id_decimal),
        .m_checksum_error (m_checksum_error),
        .m_alarm_flag     (m_alarm_flag),
        .m_filter_level   (m_filter_level),
        .m_field_strength (m_field_strength),
        .m_low_battery    (m_low_battery)
    );

endmodule
